/* hw/rtl/bsl_pkg.sv */
// shared types, codes and constants of the bounded sequential list
`timescale 1ns / 1ps

package bsl_pkg;

    // default sizing
    localparam int unsigned CAPACITY_DEF   = 64;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // fixed field widths of the request and result beats
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FOUND_W  = 6;
    localparam int unsigned COUNT_W  = 7;

    // request operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_INSERT     = 3'd4,
        MODE_ERASE      = 3'd5,
        MODE_FIND       = 3'd6
    } mode_e;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_e;

    // what the current request does to the store
    typedef enum logic [2:0] {
        PLAN_NONE,
        PLAN_APPEND,
        PLAN_DROP,
        PLAN_UP,
        PLAN_DOWN,
        PLAN_SCAN
    } plan_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic put;
        logic take;
        logic post;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        plan_t kind;
        logic  walk_empty;
        logic  last;
        logic  hit;
    } sts_t;

endpackage

/* hw/rtl/bsl_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module bsl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bsl_ctrl.sv */
// sequencing state machine of the bounded sequential list
`timescale 1ns / 1ps

module bsl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  bsl_pkg::sts_t sts,
    output bsl_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_WALK,
        S_DRAIN,
        S_PLACE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // result beat leaves the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load      = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.start = 1'b1;
                unique case (sts.kind)
                    bsl_pkg::PLAN_APPEND:
                    begin
                        cmd.put    = 1'b1;
                        state_next = S_DONE;
                    end
                    bsl_pkg::PLAN_UP, bsl_pkg::PLAN_SCAN:
                    begin
                        state_next = S_WALK;
                    end
                    bsl_pkg::PLAN_DOWN:
                    begin
                        state_next = sts.walk_empty ? S_DONE : S_WALK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WALK:
            begin
                // a scan stops at its first match
                if (sts.hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    if (sts.last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                // last read data is moved or compared here
                cmd.take   = sts.hit;
                state_next = (sts.kind == bsl_pkg::PLAN_UP) ? S_PLACE : S_DONE;
            end
            S_PLACE:
            begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.post       = 1'b1;
                    out_valid_next = 1'b1;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/bsl_dp.sv */
// datapath of the bounded sequential list: request registers, store, walk and result
`timescale 1ns / 1ps

module bsl_dp #(
    parameter int unsigned CAPACITY   = bsl_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = bsl_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bsl_pkg::MODE_W-1:0]   mode,
    input  logic [bsl_pkg::VALUE_W-1:0]  value,
    input  logic [bsl_pkg::POS_W-1:0]    position,
    output logic [bsl_pkg::STATUS_W-1:0] status,
    output logic [bsl_pkg::FOUND_W-1:0]  found_index,
    output logic [bsl_pkg::COUNT_W-1:0]  count,
    input  bsl_pkg::cmd_t                cmd,
    output bsl_pkg::sts_t                sts
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned LW = (CW > bsl_pkg::POS_W) ? CW : bsl_pkg::POS_W;
    localparam int unsigned OW = (CW > bsl_pkg::COUNT_W) ? CW : bsl_pkg::COUNT_W;
    localparam int unsigned FW = (AW > bsl_pkg::FOUND_W) ? AW : bsl_pkg::FOUND_W;

    // request and list state
    bsl_pkg::mode_e              mode_reg;
    logic [DATA_WIDTH-1:0]       word_reg;
    logic [bsl_pkg::POS_W-1:0]   pos_reg;
    logic [CW-1:0]               count_reg, count_next;

    // walk state
    logic [AW-1:0]               ptr_reg;
    logic                        lag_vld_reg;
    logic [AW-1:0]               lag_addr_reg;
    logic                        found_vld_reg;
    logic [AW-1:0]               found_addr_reg;

    // result register
    logic [bsl_pkg::STATUS_W-1:0] status_reg;
    logic [bsl_pkg::FOUND_W-1:0]  found_index_reg;
    logic [bsl_pkg::COUNT_W-1:0]  count_out_reg;

    logic [63:0]                 value_ext;
    logic [LW-1:0]               pos_w, cnt_w, tgt_w;
    logic [AW-1:0]               tgt_a, cnt_m1, start_a, end_a;
    logic                        full, empty, bad_pos;
    bsl_pkg::plan_t              kind;
    bsl_pkg::status_e            err;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [DATA_WIDTH-1:0]       wr_data;
    logic [DATA_WIDTH-1:0]       rd_data;
    logic                        hit;
    logic [OW-1:0]               count_ext;
    logic [FW-1:0]               found_ext;
    bsl_pkg::status_e            res_status;

    // stored word is the sign-extended value cut to the data width
    assign value_ext = {{32{value[bsl_pkg::VALUE_W-1]}}, value};

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= bsl_pkg::mode_e'(mode);
            word_reg <= value_ext[DATA_WIDTH-1:0];
            pos_reg  <= position;
        end
    end

    // plan of the request from the current count
    assign pos_w   = LW'(pos_reg);
    assign cnt_w   = LW'(count_reg);
    assign full    = (cnt_w >= LW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign bad_pos = (pos_w >= cnt_w);
    assign tgt_w   = (mode_reg == bsl_pkg::MODE_PUSH_FRONT ||
                      mode_reg == bsl_pkg::MODE_POP_FRONT) ? '0 : pos_w;
    assign tgt_a   = tgt_w[AW-1:0];
    assign cnt_m1  = AW'(count_reg - CW'(1));

    always_comb
    begin
        kind = bsl_pkg::PLAN_NONE;
        err  = bsl_pkg::ST_OK;
        unique case (mode_reg)
            bsl_pkg::MODE_PUSH_BACK:
            begin
                if (full) err = bsl_pkg::ST_FULL;
                else      kind = bsl_pkg::PLAN_APPEND;
            end
            bsl_pkg::MODE_PUSH_FRONT:
            begin
                if (full)       err = bsl_pkg::ST_FULL;
                else if (empty) kind = bsl_pkg::PLAN_APPEND;
                else            kind = bsl_pkg::PLAN_UP;
            end
            bsl_pkg::MODE_POP_BACK:
            begin
                if (empty) err = bsl_pkg::ST_EMPTY;
                else       kind = bsl_pkg::PLAN_DROP;
            end
            bsl_pkg::MODE_POP_FRONT:
            begin
                if (empty) err = bsl_pkg::ST_EMPTY;
                else       kind = bsl_pkg::PLAN_DOWN;
            end
            bsl_pkg::MODE_INSERT:
            begin
                // position is checked before fullness
                if (bad_pos)   err = bsl_pkg::ST_BADPOS;
                else if (full) err = bsl_pkg::ST_FULL;
                else           kind = bsl_pkg::PLAN_UP;
            end
            bsl_pkg::MODE_ERASE:
            begin
                if (bad_pos) err = bsl_pkg::ST_BADPOS;
                else         kind = bsl_pkg::PLAN_DOWN;
            end
            bsl_pkg::MODE_FIND:
            begin
                if (empty) err = bsl_pkg::ST_NOTFOUND;
                else       kind = bsl_pkg::PLAN_SCAN;
            end
            default:
            begin
                kind = bsl_pkg::PLAN_NONE;
            end
        endcase
    end

    // walk bounds: up walks down from the top, down and scan walk upward
    always_comb
    begin
        case (kind)
            bsl_pkg::PLAN_UP:
            begin
                start_a = cnt_m1;
                end_a   = tgt_a;
            end
            bsl_pkg::PLAN_DOWN:
            begin
                start_a = tgt_a + AW'(1);
                end_a   = cnt_m1;
            end
            default:
            begin
                start_a = '0;
                end_a   = cnt_m1;
            end
        endcase
    end

    // walk pointer and read lag tracking
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ptr_reg <= start_a;
        end
        else if (cmd.rd)
        begin
            ptr_reg <= (kind == bsl_pkg::PLAN_UP) ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
        end
        if (cmd.rd)
        begin
            lag_addr_reg <= ptr_reg;
        end
        if (cmd.take)
        begin
            found_addr_reg <= lag_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_vld_reg   <= 1'b0;
            found_vld_reg <= 1'b0;
        end
        else
        begin
            lag_vld_reg <= cmd.rd;
            if (cmd.load)
            begin
                found_vld_reg <= 1'b0;
            end
            else if (cmd.take)
            begin
                found_vld_reg <= 1'b1;
            end
        end
    end

    // store write: shifted entry or the new word
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = lag_addr_reg;
        wr_data = rd_data;
        if (cmd.put)
        begin
            wr_en   = 1'b1;
            wr_addr = (kind == bsl_pkg::PLAN_APPEND) ? count_reg[AW-1:0] : tgt_a;
            wr_data = word_reg;
        end
        else if (lag_vld_reg && kind == bsl_pkg::PLAN_UP)
        begin
            wr_en   = 1'b1;
            wr_addr = lag_addr_reg + AW'(1);
        end
        else if (lag_vld_reg && kind == bsl_pkg::PLAN_DOWN)
        begin
            wr_en   = 1'b1;
            wr_addr = lag_addr_reg - AW'(1);
        end
    end

    bsl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_bsl_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // scan compare on the word that just came out of the store
    assign hit = lag_vld_reg && (kind == bsl_pkg::PLAN_SCAN) && (rd_data == word_reg);

    assign sts.kind       = kind;
    assign sts.walk_empty = ((tgt_w + LW'(1)) == cnt_w);
    assign sts.last       = (ptr_reg == end_a);
    assign sts.hit        = hit;

    // count after the request
    always_comb
    begin
        count_next = count_reg;
        case (kind)
            bsl_pkg::PLAN_APPEND, bsl_pkg::PLAN_UP:
            begin
                count_next = count_reg + CW'(1);
            end
            bsl_pkg::PLAN_DROP, bsl_pkg::PLAN_DOWN:
            begin
                count_next = count_reg - CW'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.post)
        begin
            count_reg <= count_next;
        end
    end

    // result beat fields
    assign count_ext = OW'(count_next);
    assign found_ext = FW'(found_addr_reg);

    always_comb
    begin
        if (kind == bsl_pkg::PLAN_SCAN)
        begin
            res_status = found_vld_reg ? bsl_pkg::ST_OK : bsl_pkg::ST_NOTFOUND;
        end
        else
        begin
            res_status = err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            status_reg      <= res_status;
            found_index_reg <= found_vld_reg ? found_ext[bsl_pkg::FOUND_W-1:0] : '0;
            count_out_reg   <= count_ext[bsl_pkg::COUNT_W-1:0];
        end
    end

    assign status      = status_reg;
    assign found_index = found_index_reg;
    assign count       = count_out_reg;

endmodule

/* hw/rtl/bounded_sequential_list_top.sv */
// top level of the bounded sequential list
`timescale 1ns / 1ps

// Ordered list of data words with push/pop at either end, insert and erase
// at a position, and find of the first equal word.
// Request channel: in_valid/in_ready carry mode, value and position; one
// beat at a time is worked on, and in_ready stays low from accept until the
// result has been placed in the output register.
// Result channel: out_valid/out_ready carry status, found_index and count,
// one result beat per request beat, in request order.
// Each accepted request is planned; push back, pop back, push front into
// an empty list, erase or pop front of the last entry, any refused request
// and an empty-list find are then done; other erases and pop fronts walk
// the entries and drain, finds walk until a match or else drain, and
// insert and push front walk, drain and place the new word, with at most
// CAPACITY entries walked. The walk reads one store entry per cycle through
// the single read port of the entry memory, and the next request beat can
// be taken from the cycle after the result is posted.
// Reset empties the list; the store contents are not cleared.
// If the receiver stalls, the result waits in the output register while
// the next request is accepted and worked on; its result is posted once
// the earlier beat has been taken.
module bounded_sequential_list_top #(
    parameter int unsigned CAPACITY   = bsl_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = bsl_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bsl_pkg::MODE_W-1:0]   mode,
    input  logic [bsl_pkg::VALUE_W-1:0]  value,
    input  logic [bsl_pkg::POS_W-1:0]    position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bsl_pkg::STATUS_W-1:0] status,
    output logic [bsl_pkg::FOUND_W-1:0]  found_index,
    output logic [bsl_pkg::COUNT_W-1:0]  count
);

    bsl_pkg::cmd_t cmd;
    bsl_pkg::sts_t sts;

    // sequencing
    bsl_ctrl u_bsl_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store and result path
    bsl_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_bsl_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .value       (value),
        .position    (position),
        .status      (status),
        .found_index (found_index),
        .count       (count),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

/* hw/rtl/bsl_checker.sv */
// port-level checks of the bounded sequential list, bound to the top level
`timescale 1ns / 1ps

module bsl_checker #(
    parameter int unsigned CAPACITY = bsl_pkg::CAPACITY_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bsl_pkg::STATUS_W-1:0] status,
    input logic [bsl_pkg::FOUND_W-1:0]  found_index,
    input logic [bsl_pkg::COUNT_W-1:0]  count
);

    localparam logic [bsl_pkg::COUNT_W-1:0] CapCount =
        bsl_pkg::COUNT_W'(CAPACITY % (1 << bsl_pkg::COUNT_W));

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(found_index) && $stable(count))
        else $error("result beat changed while stalled");

    // one request at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    // found index is zero unless the request succeeded
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bsl_pkg::ST_OK |-> found_index == '0)
        else $error("found index set on a failed request");

    // a full refusal reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bsl_pkg::ST_FULL |-> count == CapCount)
        else $error("full status with a list that is not full");

    // an empty refusal reports an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bsl_pkg::ST_EMPTY |-> count == '0)
        else $error("empty status with a list that is not empty");

endmodule

bind bounded_sequential_list_top bsl_checker #(
    .CAPACITY (CAPACITY)
) u_bsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .count       (count)
);
